/* rtl/mfgpw_pkg.sv */
// Shared types, codes and constants of the monochrome frame buffer panel writer.
// No dependencies; every other file refers to it by scoped names.
package mfgpw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 160;
  localparam int ROW_BYTES_DEF     = (SCREEN_WIDTH_DEF + 7) / 8;
  localparam int STORE_DEPTH_DEF   = ROW_BYTES_DEF * SCREEN_HEIGHT_DEF;

  // Operation codes
  localparam logic [2:0] OP_DRAW    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_REFRESH = 3'd3;
  localparam logic [2:0] OP_STREAM  = 3'd4;
  localparam logic [2:0] OP_WINDOW  = 3'd5;
  localparam logic [2:0] OP_FILL    = 3'd6;
  localparam logic [2:0] OP_ADDR    = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Panel command and data bytes
  localparam logic [7:0] COL_BASE    = 8'h25;
  localparam logic [7:0] CMD_ROW_LO  = 8'h60;
  localparam logic [7:0] CMD_ROW_HI  = 8'h70;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] CMD_WIN_X0  = 8'hF4;
  localparam logic [7:0] CMD_WIN_X1  = 8'hF6;
  localparam logic [7:0] CMD_WIN_Y0  = 8'hF5;
  localparam logic [7:0] CMD_WIN_Y1  = 8'hF7;
  localparam logic [3:0] NIB_LIT     = 4'hF;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       color;
    logic [7:0] fill_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       pixel;
    logic       ok;
    logic       last;
  } out_item_t;

  // n / 3 by reciprocal multiply, exact for n below 768 (the quotient is 8 bits wide)
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [20:0] prod;
    prod = 21'(n) * 21'd683;
    return prod[18:11];
  endfunction

endpackage

/* rtl/mono_framebuffer_gray_panel_writer_top.sv */
// Top level of the monochrome frame buffer panel writer: sequencer and formatter.
// Depends on mfgpw_pkg and mfgpw_ram (the 1-bit-per-pixel frame store).
//
// The block holds a 1 bpp frame store in one single-port RAM and turns commands
// into panel command/data bytes. A transaction is taken when start is high and
// busy is low; busy stays high until the item's last result has been issued.
// Results appear one per cycle on out_item, each marked by a one-cycle
// out_strobe, and cannot be held off: the receiver must take every strobe.
// The final result of an item carries last. After reset the store is swept to
// zero, one entry per cycle, and busy stays high until all STORE_DEPTH entries
// (3200 at the default 160x160 size) are cleared, before the first transaction.
// The single RAM port serializes the work: every read-modify-write and each of
// the two group reads gets its own RAM access, and the result register issues
// one byte per cycle.
module mono_framebuffer_gray_panel_writer_top #(
  parameter int SCREEN_WIDTH  = mfgpw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfgpw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mfgpw_pkg::in_item_t  in_item,
  output logic                 busy,
  output logic                 out_strobe,
  output mfgpw_pkg::out_item_t out_item
);

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int RBW       = $clog2(ROW_BYTES + 1);
  localparam int IW        = 8 + RBW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CALC, S_RD_PIX, S_MOD, S_RD_LO, S_RD_HI, S_CAP_HI,
    S_FILL, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;
  logic [7:0]           fill_r, fill_nxt;
  mfgpw_pkg::in_item_t  item_r, item_nxt;
  logic [AW-1:0]        pix_idx_r, pix_idx_nxt;
  logic [AW-1:0]        lo_idx_r, lo_idx_nxt;
  logic [AW-1:0]        hi_idx_r, hi_idx_nxt;
  logic [7:0]           lo_r, lo_nxt;
  logic [2:0]           grp_r, grp_nxt;
  logic                 pix_r, pix_nxt;
  mfgpw_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 out_strobe_r, out_strobe_nxt;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  // Decoded item
  logic                 pix_ok, byte_ok;
  logic [8+RBW-1:0]     row_base;
  logic [7:0]           grp_q, grp_x, col_addr;
  logic [8:0]           grp_end;
  logic [5:0]           hi_col;
  logic [7:0]           res_byte;
  mfgpw_pkg::out_item_t res;
  logic [7:0]           modified;
  logic [2:0]           grp_bits;

  mfgpw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Coordinate checks and store addressing for the held transaction
  assign pix_ok   = (item_r.x_pos < 8'(SCREEN_WIDTH)) && (item_r.y_pos < 8'(SCREEN_HEIGHT));
  assign byte_ok  = (item_r.x_pos < 8'(ROW_BYTES)) && (item_r.y_pos < 8'(SCREEN_HEIGHT));
  assign row_base = (8+RBW)'(item_r.y_pos) * (8+RBW)'(ROW_BYTES);
  assign grp_q    = mfgpw_pkg::div3({2'b00, item_r.x_pos});
  assign grp_x    = 8'(grp_q * 8'd3);
  assign grp_end  = {1'b0, grp_x} + 9'd2;
  // The third group pixel may fall past the row; it reads as 0 then, so stay in the row.
  assign hi_col   = (grp_end[8:3] >= 6'(ROW_BYTES)) ? {1'b0, grp_x[7:3]} : grp_end[8:3];
  assign col_addr = mfgpw_pkg::COL_BASE + grp_q;
  assign modified = item_r.color ? (ram_rdata | (8'h80 >> item_r.x_pos[2:0]))
                                 : (ram_rdata & ~(8'h80 >> item_r.x_pos[2:0]));

  // Pick the three group pixels out of the low and high store bytes
  always_comb begin
    logic [8:0] col;
    logic [7:0] src;
    for (int j = 0; j < 3; j++) begin
      col = {1'b0, grp_x} + 9'(j);
      src = (col[8:3] == {1'b0, grp_x[7:3]}) ? lo_r : ram_rdata;
      grp_bits[j] = src[~col[2:0]] && (col < 9'(SCREEN_WIDTH));
    end
  end

  // Address sequence byte for step k of an address or group transfer
  always_comb begin
    case (k_r[1:0])
      2'd0:    res_byte = mfgpw_pkg::CMD_ROW_LO | {4'h0, item_r.y_pos[3:0]};
      2'd1:    res_byte = mfgpw_pkg::CMD_ROW_HI | {4'h0, item_r.y_pos[7:4]};
      2'd2:    res_byte = {4'h0, col_addr[3:0]};
      default: res_byte = mfgpw_pkg::CMD_COL_HI | {4'h0, col_addr[7:4]};
    endcase
  end

  // Result formatter: step k_r of the held transaction
  always_comb begin
    res          = '0;
    res.ok       = 1'b1;
    res.kind     = mfgpw_pkg::KIND_CMD;
    case (item_r.op)
      mfgpw_pkg::OP_DRAW, mfgpw_pkg::OP_REFRESH: begin
        if (!pix_ok) begin
          res.kind = mfgpw_pkg::KIND_STATUS;
          res.ok   = 1'b0;
          res.last = 1'b1;
        end else if (k_r < 3'd4) begin
          res.out_byte = res_byte;
        end else if (k_r == 3'd4) begin
          res.kind     = mfgpw_pkg::KIND_DATA;
          res.out_byte = {{4{grp_r[0]}}, {4{grp_r[1]}}};
        end else begin
          res.kind     = mfgpw_pkg::KIND_DATA;
          res.out_byte = {{4{grp_r[2]}}, 4'h0};
          res.last     = 1'b1;
        end
      end
      mfgpw_pkg::OP_WRITE: begin
        res.kind = mfgpw_pkg::KIND_STATUS;
        res.ok   = pix_ok;
        res.last = 1'b1;
      end
      mfgpw_pkg::OP_READ: begin
        res.kind  = mfgpw_pkg::KIND_STATUS;
        res.ok    = pix_ok;
        res.pixel = pix_ok && pix_r;
        res.last  = 1'b1;
      end
      mfgpw_pkg::OP_STREAM: begin
        if (!byte_ok) begin
          res.kind = mfgpw_pkg::KIND_STATUS;
          res.ok   = 1'b0;
          res.last = 1'b1;
        end else begin
          res.kind = mfgpw_pkg::KIND_DATA;
          case (k_r)
            3'd0:    res.out_byte = {{4{lo_r[7]}}, {4{lo_r[6]}}};
            3'd1:    res.out_byte = {{4{lo_r[5]}}, {4{lo_r[4]}}};
            3'd2:    res.out_byte = {{4{lo_r[3]}}, {4{lo_r[2]}}};
            3'd3:    res.out_byte = {{4{lo_r[1]}}, {4{lo_r[0]}}};
            default: res.out_byte = 8'h00;
          endcase
          // Pad the row end with one blank data byte
          if (item_r.x_pos == 8'(ROW_BYTES - 1)) begin
            res.last = (k_r == 3'd4);
          end else begin
            res.last = (k_r == 3'd3);
          end
        end
      end
      mfgpw_pkg::OP_WINDOW: begin
        case (k_r)
          3'd0:    res.out_byte = mfgpw_pkg::CMD_WIN_X0;
          3'd1:    res.out_byte = mfgpw_pkg::COL_BASE + grp_q;
          3'd2:    res.out_byte = mfgpw_pkg::CMD_WIN_X1;
          3'd3:    res.out_byte = mfgpw_pkg::COL_BASE
                                  + mfgpw_pkg::div3({2'b00, item_r.x_end} + 10'd2);
          3'd4:    res.out_byte = mfgpw_pkg::CMD_WIN_Y0;
          3'd5:    res.out_byte = item_r.y_pos;
          3'd6:    res.out_byte = mfgpw_pkg::CMD_WIN_Y1;
          default: res.out_byte = item_r.y_end;
        endcase
        res.last = (k_r == 3'd7);
      end
      mfgpw_pkg::OP_FILL: begin
        res.kind = mfgpw_pkg::KIND_STATUS;
        res.last = 1'b1;
      end
      default: begin
        res.out_byte = res_byte;
        res.last     = (k_r == 3'd3);
      end
    endcase
  end

  // Sequencer next state and RAM control
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    sweep_nxt      = sweep_r;
    fill_nxt       = fill_r;
    item_nxt       = item_r;
    pix_idx_nxt    = pix_idx_r;
    lo_idx_nxt     = lo_idx_r;
    hi_idx_nxt     = hi_idx_r;
    lo_nxt         = lo_r;
    grp_nxt        = grp_r;
    pix_nxt        = pix_r;
    out_item_nxt   = out_item_r;
    out_strobe_nxt = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = '0;
    ram_wdata      = fill_r;

    case (state_r)
      S_CLEAR, S_FILL: begin
        // Sweep the whole store with the fill byte, one entry per cycle
        ram_we   = 1'b1;
        ram_addr = sweep_r;
        if (sweep_r == AW'(DEPTH - 1)) begin
          sweep_nxt = '0;
          state_nxt = (state_r == S_CLEAR) ? S_IDLE : S_EMIT;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        pix_idx_nxt = AW'(IW'(row_base) + IW'(item_r.x_pos[7:3]));
        hi_idx_nxt  = AW'(IW'(row_base) + IW'(hi_col));
        if (item_r.op == mfgpw_pkg::OP_STREAM) begin
          lo_idx_nxt = AW'(IW'(row_base) + IW'(item_r.x_pos));
        end else begin
          lo_idx_nxt = AW'(IW'(row_base) + IW'(grp_x[7:3]));
        end
        k_nxt = '0;
        if (item_r.op == mfgpw_pkg::OP_FILL) begin
          fill_nxt  = item_r.fill_byte;
          sweep_nxt = '0;
          state_nxt = S_FILL;
        end else if ((item_r.op inside {mfgpw_pkg::OP_DRAW, mfgpw_pkg::OP_WRITE,
                                        mfgpw_pkg::OP_READ, mfgpw_pkg::OP_REFRESH}
                      && !pix_ok)
                     || (item_r.op == mfgpw_pkg::OP_STREAM && !byte_ok)) begin
          state_nxt = S_EMIT;
        end else if (item_r.op inside {mfgpw_pkg::OP_DRAW, mfgpw_pkg::OP_WRITE,
                                       mfgpw_pkg::OP_READ}) begin
          state_nxt = S_RD_PIX;
        end else if (item_r.op inside {mfgpw_pkg::OP_REFRESH, mfgpw_pkg::OP_STREAM}) begin
          state_nxt = S_RD_LO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RD_PIX: begin
        ram_addr  = pix_idx_r;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // Read data is back: capture for read, write back for draw and store write.
        // The group reads follow in later cycles, so they see the new byte.
        ram_addr  = pix_idx_r;
        ram_wdata = modified;
        if (item_r.op == mfgpw_pkg::OP_READ) begin
          pix_nxt   = ram_rdata[~item_r.x_pos[2:0]];
          state_nxt = S_EMIT;
        end else begin
          ram_we    = 1'b1;
          state_nxt = (item_r.op == mfgpw_pkg::OP_DRAW) ? S_RD_LO : S_EMIT;
        end
      end
      S_RD_LO: begin
        ram_addr  = lo_idx_r;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        lo_nxt   = ram_rdata;
        ram_addr = hi_idx_r;
        state_nxt = (item_r.op == mfgpw_pkg::OP_STREAM) ? S_EMIT : S_CAP_HI;
      end
      S_CAP_HI: begin
        grp_nxt   = grp_bits;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Issue one result per cycle; the receiver cannot stall
        out_item_nxt   = res;
        out_strobe_nxt = 1'b1;
        if (res.last) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      k_r          <= '0;
      sweep_r      <= '0;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      sweep_r      <= sweep_nxt;
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    item_r     <= item_nxt;
    pix_idx_r  <= pix_idx_nxt;
    lo_idx_r   <= lo_idx_nxt;
    hi_idx_r   <= hi_idx_nxt;
    lo_r       <= lo_nxt;
    grp_r      <= grp_nxt;
    pix_r      <= pix_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef ASSERT_OFF
  a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ram_we)
    else $error("store written while idle");

  a_results_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside a result burst");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("accepted transaction did not raise busy");

  a_status_form : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == mfgpw_pkg::KIND_STATUS
      |-> out_item.out_byte == 8'h00 && out_item.last)
    else $error("malformed status result");

  a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_addr < AW'(DEPTH - 1) || ram_addr == AW'(DEPTH - 1))
    else $error("store write beyond depth");
`endif

endmodule

/* rtl/mfgpw_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on mfgpw_pkg for the default depth.
module mfgpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mfgpw_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
